### hdl/wtd_pkg.sv
// Shared constants and types for the weighted tree diameter block.
`default_nettype none
package wtd_pkg;
    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES + 1);
    localparam int ENTRIES   = 2 * MAX_NODES;
    localparam int LINK_W    = $clog2(ENTRIES);
    localparam int WEIGHT_W  = 16;
    localparam int DIST_W    = 32;
    localparam int ES_W      = NODE_W + WEIGHT_W + LINK_W;
    localparam int Q_W       = NODE_W + DIST_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_LINK_B,
        ST_START,
        ST_POP,
        ST_POP_W,
        ST_HEAD_W,
        ST_ES_W,
        ST_SEEN_W,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

### hdl/wtd_ram.sv
// Simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module wtd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/weighted_tree_diameter.sv
// Top level: edge loader, per-node breadth-first walk sequencer and result port.
// Usage:
//   s_* carries edges: tdata = {edge_weight, node_b, node_a}, tuser = edge_valid,
//   tlast = is_last. cfg_* writes node_count (accepted whenever offered).
//   m_* carries the single diameter result after an item with tlast set.
// Loading: a stored edge takes two head-list read/modify/write steps through
//   the list-head memory; an item that stores nothing is handled in ST_IDLE.
// Search: every start node in turn is walked through the registered memory
//   read chain queue -> list head -> edge store -> seen mark.
// After each result and after reset a clearing pass over all MAX_NODES + 1 entries
//   zeroes list heads and seen marks; no edge is accepted meanwhile.
// The result is held in an output register until m_tready; the block goes on
//   clearing and may load and search the next tree while it waits, but holds
//   the new result back until the previous one has been taken.
// aresetn is synchronous, active low; it drops any pending result.
`default_nettype none
module weighted_tree_diameter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // node_a[10:0], node_b[21:11], edge_weight[37:22]
    input  wire logic [0:0]  s_tuser,   // edge_valid[0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // diameter[31:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);
    import wtd_pkg::*;

    state_t state_reg, state_next;
    logic [NODE_W-1:0]   node_count_reg, node_count_next;
    logic [NODE_W-1:0]   edge_count_reg, edge_count_next;
    logic [NODE_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                last_reg, last_next;
    logic [NODE_W-1:0]   s_reg, s_next, rd_reg, rd_next, wr_reg, wr_next, clr_reg, clr_next;
    logic [DIST_W-1:0]   d_reg, d_next, best_reg, best_next, out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]   peer_reg, peer_next;
    logic [WEIGHT_W-1:0] ew_reg, ew_next;
    logic [LINK_W-1:0]   nxt_reg, nxt_next;

    logic                head_we, es_we, seen_we, q_we;
    logic [NODE_W-1:0]   head_waddr, head_raddr, head_wdata, head_rdata;
    logic [LINK_W-1:0]   es_waddr, es_raddr;
    logic [ES_W-1:0]     es_wdata, es_rdata;
    logic [NODE_W-1:0]   seen_waddr, seen_raddr, seen_wdata, seen_rdata;
    logic [NODE_W-1:0]   q_waddr, q_raddr;
    logic [Q_W-1:0]      q_wdata, q_rdata;

    logic [NODE_W-1:0]   n_used;
    logic [LINK_W-1:0]   ent_a, ent_b;
    logic                edge_ok;
    logic [DIST_W:0]     sum;
    logic [DIST_W-1:0]   q_dist;

    wtd_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(NODE_W)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));
    wtd_ram #(.DEPTH(ENTRIES), .WIDTH(ES_W)) u_es (
        .aclk(aclk), .we(es_we), .waddr(es_waddr), .wdata(es_wdata),
        .raddr(es_raddr), .rdata(es_rdata));
    wtd_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(NODE_W)) u_seen (
        .aclk(aclk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
        .raddr(seen_raddr), .rdata(seen_rdata));
    wtd_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(Q_W)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    assign n_used = (node_count_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count_reg;
    assign ent_a  = {edge_count_reg[LINK_W-2:0], (a_reg > b_reg)};
    assign ent_b  = {edge_count_reg[LINK_W-2:0], (b_reg > a_reg)};
    assign q_dist = q_rdata[Q_W-1:NODE_W];
    assign sum    = {1'b0, d_reg} + {{(DIST_W + 1 - WEIGHT_W){1'b0}}, ew_reg};

    always_comb begin
        edge_ok = s_tuser[0] && (s_tdata[10:0] != '0) && (s_tdata[21:11] != '0)
                  && (s_tdata[10:0] <= n_used) && (s_tdata[21:11] <= n_used)
                  && (s_tdata[10:0] != s_tdata[21:11])
                  && (edge_count_reg < NODE_W'(MAX_NODES - 1));
    end

    always_comb begin
        state_next      = state_reg;
        node_count_next = cfg_valid ? cfg_data : node_count_reg;
        edge_count_next = edge_count_reg;
        a_next = a_reg;  b_next = b_reg;  w_next = w_reg;  last_next = last_reg;
        s_next = s_reg;  rd_next = rd_reg;  wr_next = wr_reg;  clr_next = clr_reg;
        d_next = d_reg;  best_next = best_reg;  out_next = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        peer_next = peer_reg;  ew_next = ew_reg;  nxt_next = nxt_reg;
        head_we = 1'b0;  head_waddr = '0;  head_wdata = '0;  head_raddr = '0;
        es_we = 1'b0;    es_waddr = '0;    es_wdata = '0;    es_raddr = '0;
        seen_we = 1'b0;  seen_waddr = '0;  seen_wdata = '0;  seen_raddr = '0;
        q_we = 1'b0;     q_waddr = '0;     q_wdata = '0;     q_raddr = '0;

        case (state_reg)
            ST_CLEAR: begin
                head_we = 1'b1;  head_waddr = clr_reg;
                seen_we = 1'b1;  seen_waddr = clr_reg;
                edge_count_next = '0;
                if (clr_reg == NODE_W'(MAX_NODES)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    a_next    = s_tdata[10:0];
                    b_next    = s_tdata[21:11];
                    w_next    = s_tdata[37:22];
                    last_next = s_tlast;
                    if (edge_ok) begin
                        state_next = ST_LOAD_A;
                    end else if (s_tlast) begin
                        best_next  = '0;
                        s_next     = NODE_W'(1);
                        state_next = ST_START;
                    end
                end
            end
            ST_LOAD_A: begin
                head_raddr = a_reg;
                state_next = ST_LOAD_B;
            end
            ST_LOAD_B: begin
                es_we = 1'b1;  es_waddr = ent_a;  es_wdata = {head_rdata, w_reg, b_reg};
                head_we = 1'b1;  head_waddr = a_reg;  head_wdata = ent_a + 1'b1;
                head_raddr = b_reg;
                state_next = ST_LINK_B;
            end
            ST_LINK_B: begin
                es_we = 1'b1;  es_waddr = ent_b;  es_wdata = {head_rdata, w_reg, a_reg};
                head_we = 1'b1;  head_waddr = b_reg;  head_wdata = ent_b + 1'b1;
                edge_count_next = edge_count_reg + 1'b1;
                if (last_reg) begin
                    best_next  = '0;
                    s_next     = NODE_W'(1);
                    state_next = ST_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_START: begin
                if (s_reg > n_used) begin
                    state_next = ST_OUT;
                end else begin
                    seen_we = 1'b1;  seen_waddr = s_reg;  seen_wdata = s_reg;
                    q_we = 1'b1;  q_waddr = '0;  q_wdata = {{DIST_W{1'b0}}, s_reg};
                    rd_next = '0;
                    wr_next = NODE_W'(1);
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (rd_reg == wr_reg) begin
                    s_next     = s_reg + 1'b1;
                    state_next = ST_START;
                end else begin
                    q_raddr    = rd_reg;
                    rd_next    = rd_reg + 1'b1;
                    state_next = ST_POP_W;
                end
            end
            ST_POP_W: begin
                d_next = q_dist;
                if (q_dist > best_reg) begin
                    best_next = q_dist;
                end
                head_raddr = q_rdata[NODE_W-1:0];
                state_next = ST_HEAD_W;
            end
            ST_HEAD_W: begin
                if (head_rdata == '0) begin
                    state_next = ST_POP;
                end else begin
                    es_raddr   = head_rdata - 1'b1;
                    state_next = ST_ES_W;
                end
            end
            ST_ES_W: begin
                peer_next  = es_rdata[NODE_W-1:0];
                ew_next    = es_rdata[NODE_W+WEIGHT_W-1:NODE_W];
                nxt_next   = es_rdata[ES_W-1:NODE_W+WEIGHT_W];
                seen_raddr = es_rdata[NODE_W-1:0];
                state_next = ST_SEEN_W;
            end
            ST_SEEN_W: begin
                if ((seen_rdata != s_reg) && (wr_reg <= NODE_W'(MAX_NODES))) begin
                    seen_we = 1'b1;  seen_waddr = peer_reg;  seen_wdata = s_reg;
                    q_we = 1'b1;  q_waddr = wr_reg;
                    q_wdata = {(sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0]), peer_reg};
                    wr_next = wr_reg + 1'b1;
                end
                if (nxt_reg == '0) begin
                    state_next = ST_POP;
                end else begin
                    es_raddr   = nxt_reg - 1'b1;
                    state_next = ST_ES_W;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_next   = best_reg;
                    clr_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            default: begin
                clr_next   = '0;
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= NODE_W'(1);
            edge_count_reg <= '0;
            clr_reg        <= '0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edge_count_reg <= edge_count_next;
            clr_reg        <= clr_next;
            best_reg       <= best_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        w_reg    <= w_next;
        last_reg <= last_next;
        s_reg    <= s_next;
        rd_reg   <= rd_next;
        wr_reg   <= wr_next;
        d_reg    <= d_next;
        out_reg  <= out_next;
        peer_reg <= peer_next;
        ew_reg   <= ew_next;
        nxt_reg  <= nxt_next;
    end
endmodule
`default_nettype wire
